/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the circular deque files
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int WORD_W  = 32;
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 8;
	localparam int CAP_W   = 8;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_APPEND,
		CELL_TRUNC,
		CELL_CLR
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    value;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TREE1,
		S_TREE2,
		S_LOAD
	} state_t;

endpackage

/* rtl/deq_ifs.sv */
// ----------------------------------------------------------------------------
// deq_ifs
// valid/ready channels of the circular deque: command, result, capacity write
// ----------------------------------------------------------------------------
interface deq_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [deq_pkg::CMD_W-1:0]  command;
	deq_pkg::word_t             push_value;

	modport source (output valid, command, push_value, input ready);
	modport sink   (input valid, command, push_value, output ready);
endinterface

interface deq_res_if;
	logic                         valid;
	logic                         ready;
	deq_pkg::word_t               popped_value;
	logic [deq_pkg::STAT_W-1:0]   status;
	deq_pkg::word_t               front_value;
	deq_pkg::word_t               rear_value;
	logic [deq_pkg::COUNT_W-1:0]  count;
	logic                         is_empty;
	logic                         is_full;

	modport source (output valid, popped_value, status, front_value, rear_value, count,
		is_empty, is_full, input ready);
	modport sink   (input valid, popped_value, status, front_value, rear_value, count,
		is_empty, is_full, output ready);
endinterface

interface deq_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [deq_pkg::CAP_W-1:0]  capacity;

	modport source (output valid, capacity, input ready);
	modport sink   (input valid, capacity, output ready);
endinterface

/* rtl/deq_cell.sv */
// ----------------------------------------------------------------------------
// deq_cell
// one slot of the deque chain: occupancy flag and entry, shifts to neighbours
// ----------------------------------------------------------------------------
module deq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  deq_pkg::cell_ctrl_t ctrl,
	input  logic                left_occ,
	input  deq_pkg::word_t      left_data,
	input  logic                right_occ,
	input  deq_pkg::word_t      right_data,
	output logic                occ,
	output deq_pkg::word_t      data
);

	logic           occ_q;
	logic           occ_d;
	deq_pkg::word_t data_q;
	deq_pkg::word_t data_d;
	logic           data_en;

	always_comb begin
		occ_d   = occ_q;
		data_d  = data_q;
		data_en = 1'b0;
		case (ctrl.op)
			deq_pkg::CELL_SHR: begin
				occ_d   = left_occ;
				data_d  = left_data;
				data_en = 1'b1;
			end
			deq_pkg::CELL_SHL: begin
				occ_d   = right_occ;
				data_d  = right_data;
				data_en = 1'b1;
			end
			deq_pkg::CELL_APPEND: begin
				if (!occ_q && left_occ) begin
					occ_d   = 1'b1;
					data_d  = ctrl.value;
					data_en = 1'b1;
				end
			end
			deq_pkg::CELL_TRUNC: begin
				if (occ_q && !right_occ) begin
					occ_d = 1'b0;
				end
			end
			deq_pkg::CELL_CLR: begin
				occ_d = 1'b0;
			end
			default: begin
				occ_d = occ_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (data_en) begin
			data_q <= data_d;
		end
	end

	assign occ  = occ_q;
	assign data = data_q;

endmodule

/* rtl/deq_rear_sel.sv */
// ----------------------------------------------------------------------------
// deq_rear_sel
// picks the entry of the last occupied cell through a registered or-tree
// ----------------------------------------------------------------------------
module deq_rear_sel #(
	parameter int N = 255
) (
	input  logic           clk,
	input  logic [N-1:0]   last,
	input  deq_pkg::word_t cell_data [N],
	output deq_pkg::word_t rear
);

	localparam int G  = 16;
	localparam int NG = (N + G - 1) / G;

	deq_pkg::word_t grp_d  [NG];
	deq_pkg::word_t grp_s1 [NG];

	// one-hot select within each group of cells
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < G; j++) begin
				if (g * G + j < N) begin
					grp_d[g] = grp_d[g] | (cell_data[g * G + j]
						& {deq_pkg::WORD_W{last[g * G + j]}});
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	always_comb begin
		rear = '0;
		for (int g = 0; g < NG; g++) begin
			rear = rear | grp_s1[g];
		end
	end

endmodule

/* rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue built as a chain of shifting cells, front in cell 0
// ----------------------------------------------------------------------------
// a command is taken in S_IDLE, its result loaded in S_LOAD; a pop from the back
// that leaves entries behind goes via S_TREE1, S_TREE2 (new rear found through
// the two-stage select tree); one command in flight, S_LOAD waits on res stall
// reset: deque empty, capacity 255; cell entries hold no reset value
// a capacity write empties the deque and is taken only between commands
// ----------------------------------------------------------------------------
module circular_deque #(
	parameter int MAX_CAPACITY = 255
) (
	input  logic            clk,
	input  logic            arst_n,
	deq_cmd_if.sink         cmd,
	deq_cfg_if.sink         cfg,
	deq_res_if.source       res
);

	localparam int N  = MAX_CAPACITY;
	localparam int CW = $clog2(MAX_CAPACITY + 1);
	localparam int EW = (CW > deq_pkg::CAP_W) ? CW : deq_pkg::CAP_W;

	deq_pkg::state_t     state_q;
	deq_pkg::state_t     state_d;
	logic [deq_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	deq_pkg::word_t      rear_q;
	deq_pkg::word_t      rear_d;
	deq_pkg::word_t      popped_q;
	deq_pkg::word_t      popped_d;
	deq_pkg::status_t    status_q;
	deq_pkg::status_t    status_d;
	logic                go_tree;

	logic                in_accept;
	logic                cfg_accept;
	logic                load_res;
	logic                tree_done;

	logic [EW-1:0]       cap_w;
	logic [EW-1:0]       eff_cap;
	logic [EW-1:0]       count_w;
	logic                empty;
	logic                full;

	deq_pkg::cell_ctrl_t cell_ctrl;
	logic [N-1:0]        occ;
	logic [N-1:0]        left_occ;
	logic [N-1:0]        right_occ;
	logic [N-1:0]        last;
	deq_pkg::word_t      cell_data  [N];
	deq_pkg::word_t      left_data  [N];
	deq_pkg::word_t      right_data [N];
	deq_pkg::word_t      tree_rear;

	logic                out_valid_q;
	deq_pkg::word_t      out_popped_q;
	deq_pkg::status_t    out_status_q;
	deq_pkg::word_t      out_front_q;
	deq_pkg::word_t      out_rear_q;
	logic [deq_pkg::COUNT_W-1:0] out_count_q;
	logic                out_empty_q;
	logic                out_full_q;

	// capacity clamp and flags
	assign cap_w   = EW'(cap_q);
	assign eff_cap = (cap_w == '0) ? EW'(1)
		: ((cap_w > EW'(MAX_CAPACITY)) ? EW'(MAX_CAPACITY) : cap_w);
	assign count_w = EW'(count_q);
	assign empty   = (count_q == '0);
	assign full    = (count_w == eff_cap);

	// handshakes and control outputs
	assign cfg.ready  = (state_q == deq_pkg::S_IDLE);
	assign cfg_accept = cfg.valid && cfg.ready;
	assign cmd.ready  = (state_q == deq_pkg::S_IDLE) && !cfg.valid;
	assign in_accept  = cmd.valid && cmd.ready;

	always_comb begin
		load_res  = (state_q == deq_pkg::S_LOAD) && (!out_valid_q || res.ready);
		tree_done = (state_q == deq_pkg::S_TREE2);
	end

	// command decode
	always_comb begin
		cell_ctrl.op    = deq_pkg::CELL_HOLD;
		cell_ctrl.value = cmd.push_value;
		count_d         = count_q;
		rear_d          = rear_q;
		popped_d        = '0;
		status_d        = deq_pkg::STAT_OK;
		go_tree         = 1'b0;
		if (cfg_accept) begin
			cell_ctrl.op = deq_pkg::CELL_CLR;
			count_d      = '0;
		end else if (in_accept) begin
			case (deq_pkg::cmd_t'(cmd.command))
				deq_pkg::CMD_PUSH_FRONT: begin
					if (full) begin
						status_d = deq_pkg::STAT_FULL;
					end else begin
						cell_ctrl.op = deq_pkg::CELL_SHR;
						count_d      = count_q + CW'(1);
						if (empty) begin
							rear_d = cmd.push_value;
						end
					end
				end
				deq_pkg::CMD_PUSH_BACK: begin
					if (full) begin
						status_d = deq_pkg::STAT_FULL;
					end else begin
						cell_ctrl.op = deq_pkg::CELL_APPEND;
						count_d      = count_q + CW'(1);
						rear_d       = cmd.push_value;
					end
				end
				deq_pkg::CMD_POP_FRONT: begin
					if (empty) begin
						status_d = deq_pkg::STAT_EMPTY;
					end else begin
						cell_ctrl.op = deq_pkg::CELL_SHL;
						count_d      = count_q - CW'(1);
						popped_d     = cell_data[0];
					end
				end
				deq_pkg::CMD_POP_BACK: begin
					if (empty) begin
						status_d = deq_pkg::STAT_EMPTY;
					end else begin
						cell_ctrl.op = deq_pkg::CELL_TRUNC;
						count_d      = count_q - CW'(1);
						popped_d     = rear_q;
						go_tree      = (count_q != CW'(1));
					end
				end
				deq_pkg::CMD_CLEAR: begin
					cell_ctrl.op = deq_pkg::CELL_CLR;
					count_d      = '0;
				end
				default: begin
					status_d = deq_pkg::STAT_OK;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			deq_pkg::S_IDLE: begin
				if (in_accept) begin
					state_d = go_tree ? deq_pkg::S_TREE1 : deq_pkg::S_LOAD;
				end
			end
			deq_pkg::S_TREE1: state_d = deq_pkg::S_TREE2;
			deq_pkg::S_TREE2: state_d = deq_pkg::S_LOAD;
			deq_pkg::S_LOAD: begin
				if (load_res) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: state_d = deq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
			cap_q   <= deq_pkg::CAP_W'(255);
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_accept) begin
				cap_q <= cfg.capacity;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			popped_q <= popped_d;
			status_q <= status_d;
			rear_q   <= rear_d;
		end else if (tree_done) begin
			rear_q <= tree_rear;
		end
	end

	// cell chain
	assign left_occ  = N'({occ, 1'b1});
	assign right_occ = N'({1'b0, occ} >> 1);
	assign last      = occ & ~right_occ;

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_data[i] = cmd.push_value;
		end else begin : g_body
			assign left_data[i] = cell_data[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign right_data[i] = '0;
		end else begin : g_inner
			assign right_data[i] = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.left_occ   (left_occ[i]),
			.left_data  (left_data[i]),
			.right_occ  (right_occ[i]),
			.right_data (right_data[i]),
			.occ        (occ[i]),
			.data       (cell_data[i])
		);
	end

	deq_rear_sel #(
		.N (N)
	) u_rear_sel (
		.clk       (clk),
		.last      (last),
		.cell_data (cell_data),
		.rear      (tree_rear)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			out_popped_q <= popped_q;
			out_status_q <= status_q;
			out_front_q  <= empty ? '0 : cell_data[0];
			out_rear_q   <= empty ? '0 : rear_q;
			out_count_q  <= deq_pkg::COUNT_W'(count_w);
			out_empty_q  <= empty;
			out_full_q   <= full;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.popped_value = out_popped_q;
	assign res.status       = out_status_q;
	assign res.front_value  = out_front_q;
	assign res.rear_value   = out_rear_q;
	assign res.count        = out_count_q;
	assign res.is_empty     = out_empty_q;
	assign res.is_full      = out_full_q;

endmodule

/* rtl/circular_deque_chk.sv */
// ----------------------------------------------------------------------------
// circular_deque_chk
// port-level checks of the circular deque, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_deque_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input deq_pkg::word_t                res_popped_value,
	input logic [deq_pkg::STAT_W-1:0]    res_status,
	input deq_pkg::word_t                res_front_value,
	input deq_pkg::word_t                res_rear_value,
	input logic [deq_pkg::COUNT_W-1:0]   res_count,
	input logic                          res_is_empty
);

	`ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_popped_value) && $stable(res_count), "result beat changed while stalled")
	`ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready, "second command beat taken while one is in flight")
	`ASSERT_SAME(a_empty_flag, res_valid, res_is_empty == (res_count == '0), "empty flag disagrees with count")
	`ASSERT_SAME(a_empty_peek, res_valid && res_is_empty, res_front_value == '0 && res_rear_value == '0, "peek of an empty deque is not zero")
	`ASSERT_SAME(a_reject_pop, res_valid && res_status != deq_pkg::STAT_OK, res_popped_value == '0, "rejected command returned a value")

endmodule

bind circular_deque circular_deque_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_popped_value (res.popped_value),
	.res_status       (res.status),
	.res_front_value  (res.front_value),
	.res_rear_value   (res.rear_value),
	.res_count        (res.count),
	.res_is_empty     (res.is_empty)
);
